@@ sv/dht_pkg.sv @@
`timescale 1ns / 1ps

package dht_pkg;

	// Default geometry
	localparam int TABLE_SIZE_DEF   = 16;
	localparam int STEP_MODULUS_DEF = 7;
	localparam int QUEUE_DEPTH      = 2;

	// Field widths
	localparam int ACT_W   = 2;
	localparam int KEY_W   = 31;
	localparam int PRICE_W = 31;
	localparam int STAT_W  = 3;
	localparam int SLOT_W  = 4;
	localparam int MARK_W  = 2;

	// Digit-serial remainder unit: four key bits per cycle, MSB first.
	// MOD_W holds 2*r+1 for any remainder below the largest modulus (4096).
	localparam int DIGIT_W    = 4;
	localparam int KEY_DIGITS = (KEY_W + DIGIT_W - 1) / DIGIT_W;
	localparam int KEY_PAD_W  = KEY_DIGITS * DIGIT_W;
	localparam int MOD_W      = 13;

	// Request actions
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STAT_W-1:0] ST_FOUND     = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd4;

	// Slot marks
	localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
	localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
	localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [KEY_W-1:0]   key;
		logic [PRICE_W-1:0] price;
	} in_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [SLOT_W-1:0]  slot;
		logic [PRICE_W-1:0] found_price;
	} out_t;

	typedef struct packed {
		logic [MARK_W-1:0]  mark;
		logic [KEY_W-1:0]   key;
		logic [PRICE_W-1:0] price;
	} slot_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_KEY,
		FR_STEP,
		FR_SEND
	} fr_state_t;

	typedef enum logic [1:0] {
		BE_CLEAR,
		BE_IDLE,
		BE_PROBE
	} be_state_t;

	// Fold one digit into a running remainder: r = (r * 2^DIGIT_W + d) mod m,
	// one bit at a time with a single compare and subtract per bit.
	function automatic logic [MOD_W-1:0] mod_digit(input logic [MOD_W-1:0] r,
		input logic [DIGIT_W-1:0] d, input logic [MOD_W-1:0] m);
		logic [MOD_W-1:0] t;
		t = r;
		for (int i = DIGIT_W - 1; i >= 0; i--) begin
			t = {t[MOD_W-2:0], d[i]};
			if (t >= m) begin
				t = t - m;
			end
		end
		return t;
	endfunction

endpackage

@@ sv/dht_queue.sv @@
`timescale 1ns / 1ps

module dht_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = dht_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	import dht_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

@@ sv/dht_front.sv @@
`timescale 1ns / 1ps

module dht_front #(
	parameter int TABLE_SIZE   = dht_pkg::TABLE_SIZE_DEF,
	parameter int STEP_MODULUS = dht_pkg::STEP_MODULUS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  dht_pkg::in_t                      req,
	output logic                              busy,
	output logic                              q_push,
	input  logic                              q_full,
	output dht_pkg::in_t                      q_req,
	output logic [$clog2(TABLE_SIZE)-1:0]     q_h1,
	output logic [$clog2(TABLE_SIZE)-1:0]     q_stp
);
	import dht_pkg::*;

	localparam int IDX_W       = $clog2(TABLE_SIZE);
	localparam int SMR_W       = $clog2(STEP_MODULUS);
	localparam int STEP_W      = $clog2(STEP_MODULUS + 1);
	localparam int STEP_DIGITS = (STEP_W + DIGIT_W - 1) / DIGIT_W;
	localparam int STEP_PAD    = STEP_DIGITS * DIGIT_W;
	localparam int CNT_W       = $clog2(KEY_DIGITS);
	localparam logic [MOD_W-1:0] TS_M = MOD_W'(TABLE_SIZE);
	localparam logic [MOD_W-1:0] SM_M = MOD_W'(STEP_MODULUS);

	fr_state_t            state_q, state_d;
	logic [CNT_W-1:0]     dig_q;
	in_t                  req_q;
	logic [KEY_PAD_W-1:0] key_sh_q;
	logic [IDX_W-1:0]     rem_ts_q;
	logic [SMR_W-1:0]     rem_sm_q;
	logic [STEP_PAD-1:0]  stp_sh_q;
	logic [IDX_W-1:0]     stp_r_q;

	logic [DIGIT_W-1:0] key_dig;
	logic [DIGIT_W-1:0] stp_dig;
	logic [MOD_W-1:0]   ts_full;
	logic [MOD_W-1:0]   sm_full;
	logic [MOD_W-1:0]   st_full;
	logic [IDX_W-1:0]   ts_next;
	logic [SMR_W-1:0]   sm_next;
	logic [IDX_W-1:0]   st_next;
	logic [STEP_W-1:0]  step_val;
	logic               key_last;
	logic               stp_last;

	assign key_dig  = key_sh_q[KEY_PAD_W-1 -: DIGIT_W];
	assign stp_dig  = stp_sh_q[STEP_PAD-1 -: DIGIT_W];
	assign ts_full  = mod_digit(MOD_W'(rem_ts_q), key_dig, TS_M);
	assign sm_full  = mod_digit(MOD_W'(rem_sm_q), key_dig, SM_M);
	assign st_full  = mod_digit(MOD_W'(stp_r_q), stp_dig, TS_M);
	assign ts_next  = ts_full[IDX_W-1:0];
	assign sm_next  = sm_full[SMR_W-1:0];
	assign st_next  = st_full[IDX_W-1:0];
	assign step_val = STEP_W'(STEP_MODULUS) - STEP_W'(sm_next);
	assign key_last = (dig_q == CNT_W'(KEY_DIGITS - 1));
	assign stp_last = (dig_q == CNT_W'(STEP_DIGITS - 1));

	assign q_req = req_q;
	assign q_h1  = rem_ts_q;
	assign q_stp = stp_r_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FR_IDLE: if (take) state_d = FR_KEY;
			FR_KEY:  if (key_last) state_d = FR_STEP;
			FR_STEP: if (stp_last) state_d = FR_SEND;
			FR_SEND: if (!q_full) state_d = FR_IDLE;
			default: state_d = FR_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		busy   = 1'b1;
		q_push = 1'b0;
		unique case (state_q)
			FR_IDLE: busy = 1'b0;
			FR_SEND: q_push = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			dig_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == FR_IDLE || (state_q == FR_KEY && key_last)) begin
				dig_q <= '0;
			end else begin
				dig_q <= dig_q + 1'b1;
			end
		end
	end

	// Hash datapath: key remainders first, then reduce the step mod table size
	always_ff @(posedge clk) begin
		case (state_q)
			FR_IDLE: begin
				if (take) begin
					req_q    <= req;
					key_sh_q <= KEY_PAD_W'(req.key);
					rem_ts_q <= '0;
					rem_sm_q <= '0;
				end
			end
			FR_KEY: begin
				rem_ts_q <= ts_next;
				rem_sm_q <= sm_next;
				key_sh_q <= key_sh_q << DIGIT_W;
				if (key_last) begin
					stp_sh_q <= STEP_PAD'(step_val);
					stp_r_q  <= '0;
				end
			end
			FR_STEP: begin
				stp_r_q  <= st_next;
				stp_sh_q <= stp_sh_q << DIGIT_W;
			end
			default: ;
		endcase
	end

endmodule

@@ sv/dht_back.sv @@
`timescale 1ns / 1ps

module dht_back #(
	parameter int TABLE_SIZE = dht_pkg::TABLE_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  dht_pkg::in_t                  wk_req,
	input  logic [$clog2(TABLE_SIZE)-1:0] wk_h1,
	input  logic [$clog2(TABLE_SIZE)-1:0] wk_stp,
	output logic                          clearing,
	output dht_pkg::out_t                 rsp,
	output logic                          empty,
	input  logic                          pop
);
	import dht_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam logic [IDX_W:0] TS_V = (IDX_W + 1)'(TABLE_SIZE);

	slot_t mem [TABLE_SIZE];

	be_state_t          state_q, state_d;
	logic [IDX_W-1:0]   ix_q;
	logic [IDX_W-1:0]   j_q;
	logic               rvalid_q;
	logic [ACT_W-1:0]   act_q;
	logic [KEY_W-1:0]   key_q;
	logic [PRICE_W-1:0] price_q;
	logic [IDX_W-1:0]   stp_q;
	slot_t              rd_q;
	out_t               rsp_q;

	logic                    we;
	logic [IDX_W-1:0]        waddr;
	slot_t                   wdata;
	logic [IDX_W-1:0]        raddr;
	logic                    done;
	logic                    wr_hit;
	logic                    finish;
	logic                    advance;
	logic                    res_free;
	logic                    last;
	logic                    key_hit;
	out_t                    res;
	logic [IDX_W:0]          sum;
	logic [IDX_W-1:0]        nix;
	logic [SLOT_W+IDX_W-1:0] slot_ext;

	assign res_free = !rvalid_q || pop;
	assign last     = (j_q == IDX_W'(TABLE_SIZE - 1));
	assign key_hit  = (rd_q.mark == MARK_USED) && (rd_q.key == key_q);
	assign sum      = {1'b0, ix_q} + {1'b0, stp_q};
	assign nix      = (sum >= TS_V) ? IDX_W'(sum - TS_V) : sum[IDX_W-1:0];
	assign slot_ext = {{SLOT_W{1'b0}}, ix_q};
	assign rsp      = rsp_q;
	assign empty    = !rvalid_q;
	assign clearing = (state_q == BE_CLEAR);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BE_CLEAR: if (ix_q == IDX_W'(TABLE_SIZE - 1)) state_d = BE_IDLE;
			BE_IDLE:  if (!q_empty) state_d = BE_PROBE;
			BE_PROBE: if (finish) state_d = BE_IDLE;
			default:  state_d = BE_CLEAR;
		endcase
	end

	// Outputs: one probe per cycle, the next read issued while this one is checked
	always_comb begin
		q_pop   = 1'b0;
		we      = 1'b0;
		waddr   = ix_q;
		wdata   = '0;
		raddr   = ix_q;
		done    = 1'b0;
		wr_hit  = 1'b0;
		finish  = 1'b0;
		advance = 1'b0;
		res     = '0;
		res.status = ST_NOT_FOUND;
		unique case (state_q)
			BE_CLEAR: begin
				we         = 1'b1;
				wdata.mark = MARK_EMPTY;
			end
			BE_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					raddr = wk_h1;
				end
			end
			BE_PROBE: begin
				unique case (act_q)
					ACT_INSERT: begin
						if (rd_q.mark != MARK_USED) begin
							done        = 1'b1;
							wr_hit      = 1'b1;
							res.status  = ST_INSERTED;
							res.slot    = slot_ext[SLOT_W-1:0];
							wdata.mark  = MARK_USED;
							wdata.key   = key_q;
							wdata.price = price_q;
						end else if (last) begin
							done       = 1'b1;
							res.status = ST_FULL;
						end
					end
					ACT_SEARCH: begin
						if (rd_q.mark == MARK_EMPTY) begin
							done = 1'b1;
						end else if (key_hit) begin
							done            = 1'b1;
							res.status      = ST_FOUND;
							res.slot        = slot_ext[SLOT_W-1:0];
							res.found_price = rd_q.price;
						end else if (last) begin
							done = 1'b1;
						end
					end
					ACT_REMOVE: begin
						if (rd_q.mark == MARK_EMPTY) begin
							done = 1'b1;
						end else if (key_hit) begin
							done        = 1'b1;
							wr_hit      = 1'b1;
							res.status  = ST_REMOVED;
							res.slot    = slot_ext[SLOT_W-1:0];
							wdata       = rd_q;
							wdata.mark  = MARK_TOMB;
						end else if (last) begin
							done = 1'b1;
						end
					end
					default: done = 1'b1;
				endcase
				finish  = done && res_free;
				we      = wr_hit && finish;
				advance = !done;
				if (advance) begin
					raddr = nix;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BE_CLEAR;
			ix_q     <= '0;
			j_q      <= '0;
			rvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BE_CLEAR) begin
				ix_q <= ix_q + 1'b1;
			end else if (q_pop) begin
				ix_q <= wk_h1;
				j_q  <= '0;
			end else if (advance) begin
				ix_q <= nix;
				j_q  <= j_q + 1'b1;
			end
			if (finish) begin
				rvalid_q <= 1'b1;
			end else if (pop) begin
				rvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			act_q   <= wk_req.action;
			key_q   <= wk_req.key;
			price_q <= wk_req.price;
			stp_q   <= wk_stp;
		end
		if (finish) begin
			rsp_q <= res;
		end
	end

	// Slot store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

endmodule

@@ sv/double_hash_table_engine.sv @@
`timescale 1ns / 1ps

// Open-addressing hash table of key/price entries with double hashing.
// Request channel: a beat (req: action, key, price) is taken on a rising edge
// with push high and full low. Action insert, search or remove; others answer
// not found. Result channel: while empty is low, rsp (status, slot,
// found_price) holds the oldest result; pop high on an edge takes that beat.
// Every request gives exactly one result, in request order.
// Flow: the front computes key mod TABLE_SIZE and the step with a remainder
// unit that folds four key bits per cycle, reduces the step mod TABLE_SIZE
// and then hands off. A two-entry queue feeds the back end, which walks the
// probe sequence at one slot per cycle through the registered read port of
// the slot memory, probing at most TABLE_SIZE slots per request.
// The front can hash the next request while the back end walks the last one.
// Reset: after arst_n rises, a clearing pass marks every slot empty, one per
// cycle; full stays high meanwhile.
// Stall: a held result blocks only the back end once its next result is
// ready; the queue and the front keep taking requests until they fill.

module double_hash_table_engine #(
	parameter int TABLE_SIZE   = dht_pkg::TABLE_SIZE_DEF,
	parameter int STEP_MODULUS = dht_pkg::STEP_MODULUS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  dht_pkg::in_t  req,
	output logic          empty,
	input  logic          pop,
	output dht_pkg::out_t rsp
);
	import dht_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int REQ_W = $bits(in_t);
	localparam int WK_W  = REQ_W + 2 * IDX_W;

	logic             fr_busy;
	logic             take;
	logic             fr_push;
	in_t              fr_req;
	logic [IDX_W-1:0] fr_h1;
	logic [IDX_W-1:0] fr_stp;
	logic             q_full;
	logic             q_empty;
	logic             q_pop;
	logic [WK_W-1:0]  q_wdata;
	logic [WK_W-1:0]  q_rdata;
	in_t              wk_req;
	logic [IDX_W-1:0] wk_h1;
	logic [IDX_W-1:0] wk_stp;
	logic             clearing;

	// Hold off requests while the front hashes or waits to send, or the table clears
	assign full = fr_busy || clearing;
	assign take = push && !full;

	dht_front #(
		.TABLE_SIZE  (TABLE_SIZE),
		.STEP_MODULUS(STEP_MODULUS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (take),
		.req   (req),
		.busy  (fr_busy),
		.q_push(fr_push),
		.q_full(q_full),
		.q_req (fr_req),
		.q_h1  (fr_h1),
		.q_stp (fr_stp)
	);

	// Pack the hashed request as {h1, step, request}
	assign q_wdata = {fr_h1, fr_stp, fr_req};

	dht_queue #(
		.WIDTH(WK_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fr_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	assign wk_req = in_t'(q_rdata[REQ_W-1:0]);
	assign wk_stp = q_rdata[REQ_W +: IDX_W];
	assign wk_h1  = q_rdata[REQ_W + IDX_W +: IDX_W];

	dht_back #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.wk_req  (wk_req),
		.wk_h1   (wk_h1),
		.wk_stp  (wk_stp),
		.clearing(clearing),
		.rsp     (rsp),
		.empty   (empty),
		.pop     (pop)
	);

	// No result can exist while the slot store is still being cleared
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> empty)
		else $error("result present during clearing pass");

	// The back end must never start a request before the clearing pass ends
	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !q_pop)
		else $error("request dequeued during clearing pass");

	// Misses and full-table answers carry zero slot and zero price
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (rsp.status == ST_NOT_FOUND || rsp.status == ST_FULL)
		|-> rsp.slot == '0 && rsp.found_price == '0)
		else $error("miss result with nonzero slot or price");

	// Only a found result carries a price
	a_price_only_found: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && rsp.status != ST_FOUND |-> rsp.found_price == '0)
		else $error("price on a result that is not found");

endmodule

@@ sim/tb_double_hash_table_engine.sv @@
`timescale 1ns / 1ps

module tb_double_hash_table_engine;

	import dht_pkg::*;

	localparam int TABLE_SLOTS  = TABLE_SIZE_DEF;
	localparam int SLOT_IX_W    = $clog2(TABLE_SLOTS);
	localparam int STEP_MOD     = STEP_MODULUS_DEF;
	localparam int RANDOM_ITEMS = 1400;
	localparam int POOL_SIZE    = 24;
	localparam int POOL_IX_W    = $clog2(POOL_SIZE);
	localparam int RESET_CYCLES = 8;
	// Tail after the last result: front hash plus a full probe walk, with margin.
	localparam int TAIL_CYCLES  = 60;
	// Longest correct quiet stretch is the receiver hold-off; allow several times that.
	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int REPORT_CAP   = 50;

	// Unused action code: the block answers not found and changes nothing.
	localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

	typedef struct {
		in_t req;
		bit  wait_idle;
	} pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_t  req = '0;
	logic empty;
	logic pop = 1'b0;
	out_t rsp;

	// Shadow copy of the slot store, updated as requests are accepted.
	logic [MARK_W-1:0]  slot_mark  [TABLE_SLOTS];
	logic [KEY_W-1:0]   slot_key   [TABLE_SLOTS];
	logic [PRICE_W-1:0] slot_price [TABLE_SLOTS];

	pending_t req_queue [$];
	out_t     expected_rsp [$];

	int  error_count = 0;
	int  req_count = 0;
	int  rsp_count = 0;
	int  status_seen [8];
	int  idle_cycles = 0;
	bit  input_stalled = 1'b0;

	// Driver state
	int       send_gap = 0;
	bit       send_burst = 1'b0;
	logic     push_next;
	pending_t cur_item;

	// Receiver state
	int   pop_wait = 0;
	int   hold_left = 0;
	bit   recv_burst = 1'b0;
	logic pop_next;

	double_hash_table_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.req    (req),
		.empty  (empty),
		.pop    (pop),
		.rsp    (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Apply one request to the shadow table and return the result it should give.
	// Probe j visits (key mod size + j * step) mod size, step = 7 - key mod 7.
	function automatic out_t table_apply(input in_t r);
		out_t                 o;
		int                   h1;
		int                   stride;
		logic [SLOT_IX_W-1:0] ix;
		o = '0;
		o.status = ST_NOT_FOUND;
		h1 = r.key % TABLE_SLOTS;
		stride = STEP_MOD - r.key % STEP_MOD;
		case (r.action)
		ACT_INSERT: begin
			// First empty or tombstone slot on the walk takes the entry; no duplicate check.
			o.status = ST_FULL;
			for (int j = 0; j < TABLE_SLOTS; j++) begin
				ix = SLOT_IX_W'((h1 + j * stride) % TABLE_SLOTS);
				if (slot_mark[ix] != MARK_USED) begin
					slot_mark[ix] = MARK_USED;
					slot_key[ix] = r.key;
					slot_price[ix] = r.price;
					o.status = ST_INSERTED;
					o.slot = SLOT_W'(ix);
					break;
				end
			end
		end
		ACT_SEARCH, ACT_REMOVE: begin
			// Skip tombstones, stop at the first empty slot.
			for (int j = 0; j < TABLE_SLOTS; j++) begin
				ix = SLOT_IX_W'((h1 + j * stride) % TABLE_SLOTS);
				if (slot_mark[ix] == MARK_EMPTY) begin
					break;
				end
				if (slot_mark[ix] == MARK_USED && slot_key[ix] == r.key) begin
					o.slot = SLOT_W'(ix);
					if (r.action == ACT_SEARCH) begin
						o.status = ST_FOUND;
						o.found_price = slot_price[ix];
					end else begin
						o.status = ST_REMOVED;
						slot_mark[ix] = MARK_TOMB;
					end
					break;
				end
			end
		end
		default: ;
		endcase
		return o;
	endfunction

	function automatic int draw_gap(input bit burst);
		return burst ? 0 : $urandom_range(0, 10);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (error_count < REPORT_CAP) begin
			$display("[%0t] result %0d: %s got 0x%0h, want 0x%0h", $realtime, rsp_count,
				what, got, want);
		end
		error_count++;
	endtask

	task automatic add_req(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] k,
		input logic [PRICE_W-1:0] p, input bit wait_idle);
		pending_t item;
		item.req.action = act;
		item.req.key = k;
		item.req.price = p;
		item.wait_idle = wait_idle;
		req_queue.push_back(item);
	endtask

	// Driver: predict on every accepted beat, then hold off for a drawn gap and
	// present the next pending item. push stays high across back-to-back beats.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			req <= '0;
		end else begin
			push_next = push;
			if (push && full) begin
				if (hold_left > 0) begin
					input_stalled = 1'b1;
				end
			end
			if (push && !full) begin
				expected_rsp.push_back(table_apply(req));
				req_count++;
				send_gap = draw_gap(send_burst);
				if ($urandom_range(0, 39) == 0) begin
					send_burst = !send_burst;
				end
				push_next = 1'b0;
			end
			if (!push_next) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (req_queue.size() > 0 &&
					!(req_queue[0].wait_idle && expected_rsp.size() > 0)) begin
					// A marked item waits until every outstanding result has drained.
					cur_item = req_queue.pop_front();
					req <= cur_item.req;
					push_next = 1'b1;
				end
			end
			push <= push_next;
		end
	end

	// Receiver: check each popped beat against the oldest expectation, then
	// drop pop for a drawn gap. Once, hold off long enough to back the block up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			pop_next = pop;
			if (pop && !empty) begin
				status_seen[rsp.status]++;
				if (expected_rsp.size() == 0) begin
					report_mismatch("result with nothing outstanding, status",
						32'(rsp.status), '0);
				end else begin
					if (rsp.status !== expected_rsp[0].status) begin
						report_mismatch("status", 32'(rsp.status),
							32'(expected_rsp[0].status));
					end
					if (rsp.slot !== expected_rsp[0].slot) begin
						report_mismatch("slot", 32'(rsp.slot), 32'(expected_rsp[0].slot));
					end
					if (rsp.found_price !== expected_rsp[0].found_price) begin
						report_mismatch("found_price", 32'(rsp.found_price),
							32'(expected_rsp[0].found_price));
					end
					void'(expected_rsp.pop_front());
				end
				rsp_count++;
				pop_wait = draw_gap(recv_burst);
				if ($urandom_range(0, 39) == 0) begin
					recv_burst = !recv_burst;
				end
				if (rsp_count == HOLD_AT) begin
					hold_left = HOLD_CYCLES;
				end
				pop_next = (pop_wait == 0 && hold_left == 0);
			end else if (!pop) begin
				if (hold_left > 0) begin
					hold_left--;
				end else if (pop_wait > 0) begin
					pop_wait--;
				end else begin
					pop_next = 1'b1;
				end
			end
			pop <= pop_next;
		end
	end

	// Watchdog: any accepted beat on either side clears the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("no beat accepted for %0d cycles; %0d requests, %0d results",
					IDLE_LIMIT, req_count, rsp_count);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		logic [KEY_W-1:0]   key_pool [POOL_SIZE];
		logic [KEY_W-1:0]   k;
		logic [PRICE_W-1:0] p;
		logic [ACT_W-1:0]   act;
		bit                 filling;
		int                 roll;
		int                 ins_pct;

		foreach (slot_mark[i]) begin
			slot_mark[i] = MARK_EMPTY;
			slot_key[i] = '0;
			slot_price[i] = '0;
		end

		// Directed: empty table, extremes, collisions, tombstone skip and reuse,
		// spare action, and a step of 2 that only reaches the odd slots.
		add_req(ACT_SEARCH, 31'd100, 31'd0, 1'b0);
		add_req(ACT_REMOVE, 31'd100, 31'd0, 1'b0);
		add_req(ACT_INSERT, 31'd0, 31'd0, 1'b0);
		add_req(ACT_INSERT, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
		add_req(ACT_SEARCH, 31'h7FFF_FFFF, 31'd0, 1'b0);
		add_req(ACT_INSERT, 31'd16, 31'h5555_5555, 1'b0);
		add_req(ACT_INSERT, 31'd32, 31'h2AAA_AAAA, 1'b0);
		add_req(ACT_REMOVE, 31'd0, 31'd0, 1'b0);
		add_req(ACT_SEARCH, 31'd16, 31'h7FFF_FFFF, 1'b0);
		add_req(ACT_INSERT, 31'd48, 31'd1234, 1'b0);
		add_req(ACT_SPARE, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
		add_req(ACT_REMOVE, 31'd64, 31'd0, 1'b0);
		// Key 5 walks the odd slots only; the last inserts find no free slot.
		for (int i = 0; i < 7; i++) begin
			add_req(ACT_INSERT, 31'd5, 31'(i + 1), 1'b0);
		end
		// Key 19 walks the same odd slots: exhausted walk, then tombstone reuse.
		add_req(ACT_SEARCH, 31'd19, 31'd0, 1'b0);
		add_req(ACT_REMOVE, 31'd19, 31'd0, 1'b0);
		add_req(ACT_SEARCH, 31'd5, 31'd0, 1'b0);
		add_req(ACT_REMOVE, 31'd5, 31'd0, 1'b0);
		add_req(ACT_INSERT, 31'd19, 31'h1234_5678, 1'b0);

		// Random: mostly keys from a small pool so searches and removes hit,
		// randomly chosen fill and drain phases so the table both saturates and empties.
		foreach (key_pool[i]) begin
			key_pool[i] = KEY_W'($urandom());
		end
		filling = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) begin
				filling = 1'($urandom_range(0, 1));
			end
			if (n % 250 == 249) begin
				key_pool[POOL_IX_W'($urandom_range(0, POOL_SIZE - 1))] = KEY_W'($urandom());
				key_pool[POOL_IX_W'($urandom_range(0, POOL_SIZE - 1))] =
					KEY_W'($urandom_range(0, 63));
			end
			ins_pct = filling ? 45 : 20;
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				act = ACT_SPARE;
			end else if (roll < 4 + ins_pct) begin
				act = ACT_INSERT;
			end else if (roll < 34 + ins_pct) begin
				act = ACT_SEARCH;
			end else begin
				act = ACT_REMOVE;
			end
			if ($urandom_range(0, 9) < 8) begin
				k = key_pool[POOL_IX_W'($urandom_range(0, POOL_SIZE - 1))];
			end else begin
				k = KEY_W'($urandom());
			end
			case ($urandom_range(0, 15))
			0: p = '0;
			1: p = '1;
			default: p = PRICE_W'($urandom());
			endcase
			// Pause the sender until the block drains, at the start and midway.
			add_req(act, k, p, n == 0 || n == RANDOM_ITEMS / 2);
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (req_queue.size() != 0 || push || expected_rsp.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_rsp.size() != 0) begin
			report_mismatch("results still outstanding", expected_rsp.size(), '0);
		end

		$display("covered %0d requests and %0d results: %0d inserted, %0d found, %0d not found,",
			req_count, rsp_count, status_seen[ST_INSERTED], status_seen[ST_FOUND],
			status_seen[ST_NOT_FOUND]);
		$display("  %0d table full, %0d removed; input stalled under result hold-off: %0d",
			status_seen[ST_FULL], status_seen[ST_REMOVED], input_stalled);
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", error_count);
			$display("status: fail");
		end
		$finish;
	end

endmodule
